@@ design/lcbr_pkg.sv @@
// Package for the LED cube refresh core: payload widths, item codes and the
// struct that travels between the scan sequencer and the output stage.
// Depends on nothing; every other design file imports it.
`default_nettype none

package lcbr_pkg;

    localparam int CHAN_W     = 8;              // bits per colour channel
    localparam int COORD_F_W  = 3;              // width of the coordinate fields
    localparam int LAYER_F_W  = 3;              // width of the layer_on field
    localparam int COLOR_W    = 3 * CHAN_W;     // packed red, green, blue

    // Codes of the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Read stage status: a voxel word is held in the frame store read register.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

endpackage

`default_nettype wire

@@ design/lcbr_if.sv @@
// Valid/ready channel interfaces of the LED cube refresh core.
// Depends on lcbr_pkg for the payload widths.
`default_nettype none

interface lcbr_item_if;
    import lcbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [COORD_F_W-1:0] vox_x;
    logic [COORD_F_W-1:0] vox_y;
    logic [COORD_F_W-1:0] vox_z;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;

    modport source (output valid, mode, vox_x, vox_y, vox_z, red, green, blue,
                    input ready);
    modport sink   (input valid, mode, vox_x, vox_y, vox_z, red, green, blue,
                    output ready);
endinterface

interface lcbr_result_if;
    import lcbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 bit_red;
    logic                 bit_green;
    logic                 bit_blue;
    logic [LAYER_F_W-1:0] layer_on;
    logic                 latch_last;

    modport source (output valid, bit_red, bit_green, bit_blue, layer_on, latch_last,
                    input ready);
    modport sink   (input valid, bit_red, bit_green, bit_blue, layer_on, latch_last,
                    output ready);
endinterface

`default_nettype wire

@@ design/lcbr_frame_store.sv @@
// Voxel frame store: one write port, one registered read port, and a clearing
// pass after reset that zeroes every entry. Depends on lcbr_pkg.
`default_nettype none

module lcbr_frame_store #(
    parameter int ADDR_W = 9
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [lcbr_pkg::COLOR_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [lcbr_pkg::COLOR_W-1:0] rd_data,
    output logic                            clearing
);
    import lcbr_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [ADDR_W:0]    clr_cnt_reg;
    logic [ADDR_W:0]    clr_cnt_next;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    // The top bit of the sweep counter marks the end of the clearing pass.
    assign clearing     = ~clr_cnt_reg[ADDR_W];
    assign clr_cnt_next = clr_cnt_reg + (ADDR_W+1)'(1);

    always_comb
    begin
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[ADDR_W-1:0];
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

    // The owner must hold off its own writes and reads until the sweep is over.
    a_no_port_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !wr_en && !rd_en)
        else $error("frame store accessed during clearing pass");

    a_clear_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |=> !clearing)
        else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

@@ design/lcbr_bcm_ctrl.sv @@
// Layer and bit-angle modulation counters, stepped once per finished refresh tick.
// Depends on lcbr_pkg.
`default_nettype none

module lcbr_bcm_ctrl #(
    parameter int SIDE       = 8,
    parameter int COLOR_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    output logic [$clog2(SIDE)-1:0]                layer,
    output logic [$clog2(COLOR_BITS+1)-1:0]        bit_position
);
    import lcbr_pkg::*;

    localparam int LAYER_W = $clog2(SIDE);
    localparam int BP_W    = $clog2(COLOR_BITS + 1);
    localparam int TICK_W  = COLOR_BITS;
    localparam int STEP_W  = COLOR_BITS + 1;

    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [TICK_W-1:0]  tick_reg, tick_next, tick_inc;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [BP_W-1:0]    bp_reg, bp_next;
    logic [BP_W-1:0]    bp_stepped;
    logic [STEP_W-1:0]  step_stepped;
    logic               hit;

    always_comb
    begin
        layer_next = layer_reg;
        tick_next  = tick_reg;
        step_next  = step_reg;
        bp_next    = bp_reg;

        tick_inc     = tick_reg + TICK_W'(1);
        hit          = (STEP_W'(tick_inc) == step_reg);
        bp_stepped   = hit ? bp_reg + BP_W'(1) : bp_reg;
        step_stepped = hit ? {step_reg[STEP_W-2:0], 1'b0} : step_reg;

        if (advance)
        begin
            layer_next = (layer_reg == LAYER_W'(SIDE - 1)) ? '0 : layer_reg + LAYER_W'(1);
            if (bp_stepped >= BP_W'(COLOR_BITS))
            begin
                // Full modulation period done: start over at the lowest bit.
                tick_next = '0;
                step_next = STEP_W'(1);
                bp_next   = '0;
            end
            else
            begin
                tick_next = tick_inc;
                step_next = step_stepped;
                bp_next   = bp_stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg <= '0;
            tick_reg  <= '0;
            step_reg  <= STEP_W'(1);
            bp_reg    <= '0;
        end
        else
        begin
            layer_reg <= layer_next;
            tick_reg  <= tick_next;
            step_reg  <= step_next;
            bp_reg    <= bp_next;
        end
    end

    assign layer        = layer_reg;
    assign bit_position = bp_reg;

    a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(step_reg))
        else $error("step threshold is not a power of two");

    a_bp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bp_reg < BP_W'(COLOR_BITS))
        else $error("bit position out of range");

    a_tick_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        STEP_W'(tick_reg) < step_reg)
        else $error("tick count passed the step threshold");

endmodule

`default_nettype wire

@@ design/lcbr_scan_seq.sv @@
// Scan sequencer: walks one layer's rows and columns, one frame store read per
// cycle barring a stall; tracks the read stage. Depends on lcbr_pkg.
`default_nettype none

module lcbr_scan_seq #(
    parameter int SIDE = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          serpentine,
    input  wire logic [$clog2(SIDE)-1:0]       layer,
    input  wire logic                          out_free,
    input  wire logic                          done,
    output logic                               idle,
    output logic                               rd_en,
    output logic [3*$clog2(SIDE)-1:0]          rd_addr,
    output lcbr_pkg::stage_t                   stage
);
    import lcbr_pkg::*;

    localparam int COORD_W = $clog2(SIDE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    stage_t             stage_reg, stage_next;
    logic [COORD_W-1:0] col;
    logic               at_last;
    logic               issue;

    assign at_last = (x_reg == '0) && (y_reg == '0);
    // A read may only be issued when the held word leaves or nothing is held.
    assign issue   = (state_reg == ST_SCAN) && (!stage_reg.valid || out_free);
    assign col     = (serpentine && y_reg[0]) ? COORD_W'(SIDE - 1) - x_reg : x_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        stage_next = stage_reg;

        if (issue)
        begin
            stage_next.valid = 1'b1;
            stage_next.last  = at_last;
        end
        else if (stage_reg.valid && out_free)
        begin
            stage_next.valid = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    x_next     = COORD_W'(SIDE - 1);
                    y_next     = COORD_W'(SIDE - 1);
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    if (at_last)
                        state_next = ST_WAIT;
                    else if (x_reg == '0)
                    begin
                        x_next = COORD_W'(SIDE - 1);
                        y_next = y_reg - COORD_W'(1);
                    end
                    else
                        x_next = x_reg - COORD_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            stage_reg <= stage_next;
        end
    end

    assign idle    = (state_reg == ST_IDLE);
    assign rd_en   = issue;
    assign rd_addr = {layer, y_reg, col};
    assign stage   = stage_reg;

    a_no_read_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && at_last) |=> !issue)
        else $error("read issued past the end of the layer");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_WAIT)
        else $error("tick finished while the scan was not waiting");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && !out_free) |=> stage_reg.valid && $stable(stage_reg.last))
        else $error("held read word dropped during a stall");

endmodule

`default_nettype wire

@@ design/led_cube_bcm_refresh_core.sv @@
// Top level of the LED cube refresh core: configuration register, input decode,
// output register. Depends on lcbr_pkg, lcbr_if, lcbr_frame_store,
// lcbr_bcm_ctrl and lcbr_scan_seq.
//
// Usage. Items arrive on the item channel. A write item (mode MODE_WRITE) stores
// the red, green and blue intensities of one voxel in the frame store; a write
// whose coordinate is not below SIDE is dropped. A refresh tick (mode MODE_TICK)
// shifts out SIDE*SIDE results on the result channel, one per voxel of the
// current layer, rows from the top down and columns from the top down, odd rows
// mirrored when serpentine order is on, each carrying the current modulation
// bit of the three channels. The last result of a tick has latch_last set and
// names the layer to light. After the tick transfer the scan state, then the
// frame store read register, then the output register are loaded before the
// first result is offered; with the receiver always ready the rest follow one
// per cycle, since the frame store read port delivers one voxel word a cycle.
// item.ready stays low until the last result has been taken. When the receiver
// stalls, the output register and the frame store read register hold their words
// and the scan waits. After reset the frame store is zeroed by a sweep over every
// entry during which no item is accepted; the configuration register (serpentine
// order on odd rows, reset 1) may be written at any idle time.
`default_nettype none

module led_cube_bcm_refresh_core #(
    parameter int SIDE       = 8,
    parameter int COLOR_BITS = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lcbr_item_if.sink     item,
    lcbr_result_if.source result,
    input  wire logic     cfg_we,
    input  wire logic     cfg_data
);
    import lcbr_pkg::*;

    localparam int COORD_W = $clog2(SIDE);
    localparam int ADDR_W  = 3 * COORD_W;
    localparam int BP_W    = $clog2(COLOR_BITS + 1);

    logic                 serp_reg;
    logic                 clearing;
    logic                 seq_idle;
    logic                 accept;
    logic                 in_range;
    logic                 wr_en;
    logic                 start;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [COLOR_W-1:0]   rd_data;
    stage_t               stage;
    logic                 out_free;
    logic                 load;
    logic                 done;
    logic [COORD_W-1:0]   layer;
    logic [BP_W-1:0]      bit_position;
    logic [2:0]           bit_sel;
    logic                 bit_ok;

    logic                 out_valid_reg;
    logic                 bit_red_reg;
    logic                 bit_green_reg;
    logic                 bit_blue_reg;
    logic [LAYER_F_W-1:0] layer_on_reg;
    logic                 latch_last_reg;

    // Configuration register: to be written only while the core is idle; not checked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            serp_reg <= 1'b1;
        else if (cfg_we)
            serp_reg <= cfg_data;
    end

    // Input decode. The core takes an item only when no tick is in progress and
    // the frame store sweep is over.
    assign item.ready = seq_idle && !clearing;
    assign accept     = item.valid && item.ready;
    assign in_range   = (int'(item.vox_x) < SIDE) && (int'(item.vox_y) < SIDE)
                     && (int'(item.vox_z) < SIDE);
    assign wr_en      = accept && (item.mode == MODE_WRITE) && in_range;
    assign start      = accept && (item.mode == MODE_TICK);
    assign wr_addr    = {COORD_W'(item.vox_z), COORD_W'(item.vox_y), COORD_W'(item.vox_x)};

    lcbr_frame_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  ({item.red, item.green, item.blue}),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    lcbr_scan_seq #(
        .SIDE (SIDE)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .serpentine (serp_reg),
        .layer      (layer),
        .out_free   (out_free),
        .done       (done),
        .idle       (seq_idle),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .stage      (stage)
    );

    // Layer and modulation counters move on when the latch transfer is taken,
    // so they stay fixed for every result of a tick.
    lcbr_bcm_ctrl #(
        .SIDE       (SIDE),
        .COLOR_BITS (COLOR_BITS)
    ) u_bcm (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (done),
        .layer        (layer),
        .bit_position (bit_position)
    );

    // Output stage: pick the current bit of each channel from the held word.
    // Positions at or beyond the channel width give zero data bits.
    assign out_free = !out_valid_reg || result.ready;
    assign load     = stage.valid && out_free;
    assign done     = result.valid && result.ready && latch_last_reg;
    assign bit_ok   = int'(bit_position) < CHAN_W;
    assign bit_sel  = 3'(bit_position);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stage.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bit_red_reg    <= bit_ok && rd_data[2*CHAN_W + int'(bit_sel)];
            bit_green_reg  <= bit_ok && rd_data[CHAN_W + int'(bit_sel)];
            bit_blue_reg   <= bit_ok && rd_data[int'(bit_sel)];
            layer_on_reg   <= LAYER_F_W'(layer);
            latch_last_reg <= stage.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.bit_red    = bit_red_reg;
    assign result.bit_green  = bit_green_reg;
    assign result.bit_blue   = bit_blue_reg;
    assign result.layer_on   = layer_on_reg;
    assign result.latch_last = latch_last_reg;

    // Nothing may be left in the output register once the core takes items again.
    a_idle_means_drained: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !result.valid && !stage.valid)
        else $error("core ready while results are still pending");

    a_layer_stable_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.latch_last) |=> $stable(layer))
        else $error("layer changed in the middle of a tick");

endmodule

`default_nettype wire

@@ tb/led_cube_bcm_refresh_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of led_cube_bcm_refresh_core: voxel writes and refresh ticks
// go in, every shift transfer is checked against a predictor of the scan.
// Depends on lcbr_pkg, lcbr_if and the RTL of the refresh core.

module led_cube_bcm_refresh_core_tb;
    import lcbr_pkg::*;

    localparam int SIDE       = 8;
    localparam int COLOR_BITS = 8;
    localparam int VOXELS     = SIDE * SIDE * SIDE;
    localparam int PHASE_ITEMS = 40;

    // One input item as the testbench keeps it before it is offered.
    typedef struct packed {
        logic                 mode;
        logic [COORD_F_W-1:0] x;
        logic [COORD_F_W-1:0] y;
        logic [COORD_F_W-1:0] z;
        logic [CHAN_W-1:0]    r;
        logic [CHAN_W-1:0]    g;
        logic [CHAN_W-1:0]    b;
    } cube_item_t;

    // One shift transfer: the three colour bits, the layer and the latch strobe.
    typedef struct packed {
        logic                 r;
        logic                 g;
        logic                 b;
        logic [LAYER_F_W-1:0] layer;
        logic                 last;
    } shift_bits_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    lcbr_item_if   item_ch ();
    lcbr_result_if shift_ch ();

    led_cube_bcm_refresh_core #(
        .SIDE       (SIDE),
        .COLOR_BITS (COLOR_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (shift_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Free-running clock, 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Items waiting to be offered, and shift transfers the scan still owes us.
    cube_item_t  pending_items [$];
    shift_bits_t expected_shifts [$];

    // Handshake pressure, in percent of cycles.
    int send_idle_pct;
    int recv_stall_pct;

    // Predictor state: the colour store, the layer pointer and the BCM counters.
    logic [COLOR_W-1:0] cube_colors [0:VOXELS-1];
    int   cur_layer;
    int   tick_count;
    int   next_step_tick;
    int   bit_pos;
    logic serpentine_on;

    // Run statistics.
    int ticks_sent;
    int writes_sent;
    int shifts_checked;
    int mismatches;
    int deepest_bit;

    // Works out what one accepted item does. A write only updates the colour
    // store. A tick scans the current layer from the top row and top column
    // down, with odd rows mirrored when serpentine order is on, and emits the
    // current modulation bit of every voxel; then the layer and BCM counters move.
    function automatic void predict_shifts(cube_item_t it);
        int          col;
        logic [COLOR_W-1:0] word;
        shift_bits_t sb;
        if (it.mode == MODE_WRITE)
        begin
            if (it.x < SIDE && it.y < SIDE && it.z < SIDE)
                cube_colors[(int'(it.z) * SIDE + int'(it.y)) * SIDE + int'(it.x)] =
                    {it.r, it.g, it.b};
            writes_sent++;
            return;
        end
        ticks_sent++;
        if (bit_pos > deepest_bit)
            deepest_bit = bit_pos;
        for (int row = SIDE - 1; row >= 0; row--)
        begin
            for (int xc = SIDE - 1; xc >= 0; xc--)
            begin
                col = (serpentine_on && (row % 2 == 1)) ? SIDE - 1 - xc : xc;
                word = cube_colors[((cur_layer % SIDE) * SIDE + row) * SIDE + col];
                if (bit_pos < CHAN_W)
                begin
                    sb.r = word[2 * CHAN_W + bit_pos];
                    sb.g = word[CHAN_W + bit_pos];
                    sb.b = word[bit_pos];
                end
                else
                begin
                    sb.r = 1'b0;
                    sb.g = 1'b0;
                    sb.b = 1'b0;
                end
                sb.layer = LAYER_F_W'(cur_layer);
                sb.last  = (row == 0 && xc == 0);
                expected_shifts.push_back(sb);
            end
        end
        cur_layer = (cur_layer < SIDE - 1) ? cur_layer + 1 : 0;
        // Bit position steps at tick counts 1, 2, 4, ... and starts over after
        // the most significant bit has had its turn.
        tick_count++;
        if (tick_count == next_step_tick)
        begin
            next_step_tick = next_step_tick * 2;
            bit_pos++;
        end
        if (bit_pos >= COLOR_BITS)
        begin
            tick_count     = 0;
            bit_pos        = 0;
            next_step_tick = 1;
        end
    endfunction

    function automatic void push_write(int x, int y, int z, int r, int g, int b);
        cube_item_t it;
        it.mode = MODE_WRITE;
        it.x = COORD_F_W'(x);
        it.y = COORD_F_W'(y);
        it.z = COORD_F_W'(z);
        it.r = CHAN_W'(r);
        it.g = CHAN_W'(g);
        it.b = CHAN_W'(b);
        pending_items.push_back(it);
    endfunction

    // The coordinate and colour fields of a tick carry random junk; the block
    // must ignore them.
    function automatic void push_tick();
        cube_item_t it;
        it.mode = MODE_TICK;
        it.x = COORD_F_W'($urandom);
        it.y = COORD_F_W'($urandom);
        it.z = COORD_F_W'($urandom);
        it.r = CHAN_W'($urandom);
        it.g = CHAN_W'($urandom);
        it.b = CHAN_W'($urandom);
        pending_items.push_back(it);
    endfunction

    // Colour channel with the extremes weighted up.
    function automatic int pick_channel();
        int v;
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = 255;
            default: v = $urandom_range(255);
        endcase
        return v;
    endfunction

    // Driver. The item at the head of the queue is offered when the sender is
    // not idling; once offered it is held until the transfer happens. The
    // predictor runs at the edge of the transfer, on the values that were on
    // the channel just before it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.mode  <= MODE_WRITE;
            item_ch.vox_x <= '0;
            item_ch.vox_y <= '0;
            item_ch.vox_z <= '0;
            item_ch.red   <= '0;
            item_ch.green <= '0;
            item_ch.blue  <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                predict_shifts({item_ch.mode, item_ch.vox_x, item_ch.vox_y, item_ch.vox_z,
                                item_ch.red, item_ch.green, item_ch.blue});
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.mode  <= pending_items[0].mode;
                    item_ch.vox_x <= pending_items[0].x;
                    item_ch.vox_y <= pending_items[0].y;
                    item_ch.vox_z <= pending_items[0].z;
                    item_ch.red   <= pending_items[0].r;
                    item_ch.green <= pending_items[0].g;
                    item_ch.blue  <= pending_items[0].b;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each shift transfer is compared field by field with the oldest
    // expectation; a transfer with nothing expected is a failure too. The
    // receiver stalls at random at the rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        shift_bits_t got;
        shift_bits_t want;
        if (!rst_n)
        begin
            shift_ch.ready <= 1'b0;
        end
        else
        begin
            if (shift_ch.valid && shift_ch.ready)
            begin
                got = {shift_ch.bit_red, shift_ch.bit_green, shift_ch.bit_blue,
                       shift_ch.layer_on, shift_ch.latch_last};
                shifts_checked++;
                if (expected_shifts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected shift transfer rgb=%b%b%b layer=%0d last=%b",
                                 $realtime, got.r, got.g, got.b, got.layer, got.last);
                end
                else
                begin
                    want = expected_shifts.pop_front();
                    if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
                        got.layer !== want.layer || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: shift mismatch, expected rgb=%b%b%b layer=%0d last=%b",
                                     $realtime, want.r, want.g, want.b, want.layer,
                                     want.last);
                            $display("    got rgb=%b%b%b layer=%0d last=%b",
                                     got.r, got.g, got.b, got.layer, got.last);
                        end
                    end
                end
            end
            shift_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Waits until every queued item has been taken and every expected shift
    // has come back, then lets the block settle before it returns.
    task automatic wait_drained(int settle);
        while (pending_items.size() != 0 || item_ch.valid || expected_shifts.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Serpentine order is only changed while the block is idle.
    task automatic write_serpentine(logic value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        serpentine_on = value;
    endtask

    // Random stimulus of one phase: mostly ticks, so that the BCM counters
    // climb through the upper bit positions, with writes spread over the cube.
    task automatic run_phase(int idle_pct, int stall_pct, logic serp);
        write_serpentine(serp);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(99) < 70)
                push_tick();
            else
                push_write($urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                           $urandom_range(SIDE - 1), pick_channel(), pick_channel(),
                           pick_channel());
        end
        wait_drained(10);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < VOXELS; i++)
            cube_colors[i] = '0;
        cur_layer      = 0;
        tick_count     = 0;
        next_step_tick = 1;
        bit_pos        = 0;
        serpentine_on  = 1'b1;
        ticks_sent     = 0;
        writes_sent    = 0;
        shifts_checked = 0;
        mismatches     = 0;
        deepest_bit    = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, serpentine order left at its reset value. Corners and
        // both ends of an odd row of layer 0 show the mirrored read order, the
        // colours use all-zero and all-one channels and single set bits, and
        // one voxel is written twice so only the second colour must appear.
        push_write(7, 7, 0, 8'hFF, 8'h00, 8'hAA);
        push_write(0, 0, 0, 8'h00, 8'hFF, 8'h55);
        push_write(7, 0, 0, 8'h80, 8'h01, 8'hFF);
        push_write(0, 1, 0, 8'hFF, 8'hFF, 8'hFF);
        push_write(7, 1, 0, 8'h01, 8'h80, 8'h0F);
        push_write(3, 5, 0, 8'h12, 8'h34, 8'h56);
        push_write(3, 5, 0, 8'h55, 8'hAA, 8'h33);
        push_tick();
        push_write(0, 0, 1, 8'hFF, 8'hFF, 8'hFF);
        push_write(7, 7, 1, 8'hFE, 8'h02, 8'hFD);
        push_tick();
        push_tick();
        push_write(7, 7, 7, 8'hFF, 8'hFF, 8'hFF);
        push_write(0, 0, 7, 8'h0F, 8'hF0, 8'hC3);
        push_write(6, 3, 0, 8'hFF, 8'h00, 8'h00);
        // Ticks for layers 3 to 7 and the wrap back to layer 0.
        for (int i = 0; i < 6; i++)
            push_tick();
        wait_drained(10);

        // Pressure phases, each with its own serpentine setting.
        run_phase(0, 0, 1'b0);
        run_phase(84, 0, 1'b1);
        run_phase(0, 84, 1'b0);
        run_phase(29, 29, 1'b1);

        // Wait longer than a tick lasts, so that a stray transfer has time to show
        // up after the last expected one.
        wait_drained(SIDE * SIDE + 16);

        $display("Covered %0d item transfers: %0d refresh ticks and %0d voxel writes,",
                 ticks_sent + writes_sent, ticks_sent, writes_sent);
        $display("%0d shift transfers checked, bit positions up to %0d, %0d mismatches.",
                 shifts_checked, deepest_bit, mismatches);
        if (mismatches == 0 && expected_shifts.size() == 0)
            $display("led_cube_bcm_refresh_core regression: pass");
        else
            $display("led_cube_bcm_refresh_core regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #6_000_000;
        $display("led_cube_bcm_refresh_core regression: fail");
        $finish;
    end

endmodule

@@ led_cube_bcm_refresh_core.f @@
design/lcbr_pkg.sv
design/lcbr_if.sv
design/lcbr_frame_store.sv
design/lcbr_bcm_ctrl.sv
design/lcbr_scan_seq.sv
design/led_cube_bcm_refresh_core.sv
tb/led_cube_bcm_refresh_core_tb.sv
